// ===== sv/sexpt_pkg.sv =====
// Shared types and widths for the s-expression tokenizer.
package sexpt_pkg;

   // Default widths of the integer accumulator and the byte offset counter.
   localparam int INT_WIDTH_DEF    = 32;
   localparam int OFFSET_WIDTH_DEF = 32;

   // Width of the value and offset fields on the result side.
   localparam int OUT_WIDTH = 32;

   // Result queue sizing.
   localparam int REC_DEPTH = 4;
   localparam int REC_PTR_W = $clog2(REC_DEPTH);
   localparam int REC_CNT_W = $clog2(REC_DEPTH + 1);

   // Token kinds as they appear on the result side.
   typedef enum logic [3:0] {
      KIND_INT   = 4'd0,
      KIND_STR   = 4'd1,
      KIND_SYM   = 4'd2,
      KIND_SEP   = 4'd3,
      KIND_QUOTE = 4'd4,
      KIND_OPEN  = 4'd5,
      KIND_CLOSE = 4'd6,
      KIND_END   = 4'd7,
      KIND_ERR   = 4'd8
   } token_kind_type;

   // Record types: a body character or a finished token.
   localparam logic REC_BODY   = 1'b0;
   localparam logic REC_FINISH = 1'b1;

   // One byte of text, already classified by the front part.
   typedef struct packed {
      logic [7:0] char_byte;
      logic [7:0] upper_byte;
      logic       eoi;
      logic       digit;
      logic       sep;
      logic       newline;
      logic       dquote;
      logic       apos;
      logic       lpar;
      logic       rpar;
      logic       printable;
   } char_class_type;

   // One result record as it leaves the block.
   typedef struct packed {
      logic [3:0]           token_kind;
      logic                 record_type;
      logic [7:0]           body_char;
      logic [OUT_WIDTH-1:0] int_value;
      logic                 int_overflow;
      logic [OUT_WIDTH-1:0] start_offset;
      logic [OUT_WIDTH-1:0] end_offset;
      logic                 last_of_run;
   } token_rec_type;

endpackage

// ===== sv/sexpt_front.sv =====
// Front part: accepts text bytes, classifies them and queues them for the lexer.
module sexpt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [7:0]                next_byte,
   input  logic                      text_end,
   output logic                      item_valid,
   output sexpt_pkg::char_class_type item,
   input  logic                      item_take
);

   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_LPAR   = 8'h28;
   localparam logic [7:0] CH_RPAR   = 8'h29;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   sexpt_pkg::char_class_type cls;
   sexpt_pkg::char_class_type slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       take_ok;

   // Classify the incoming byte.
   always_comb begin
      cls.char_byte  = next_byte;
      cls.eoi        = text_end;
      cls.digit      = (next_byte >= CH_ZERO) && (next_byte <= CH_NINE);
      cls.newline    = (next_byte == CH_NL);
      cls.sep        = (next_byte == CH_SPACE) || (next_byte == CH_TAB) ||
                       (next_byte == CH_NL);
      cls.dquote     = (next_byte == CH_DQUOTE);
      cls.apos       = (next_byte == CH_APOS);
      cls.lpar       = (next_byte == CH_LPAR);
      cls.rpar       = (next_byte == CH_RPAR);
      cls.printable  = (next_byte >= CH_SPACE) && (next_byte <= CH_TILDE);
      cls.upper_byte = ((next_byte >= CH_LOW_A) && (next_byte <= CH_LOW_Z)) ?
                       (next_byte - CASE_GAP) : next_byte;
   end

   assign full       = (count_ff == 2'd2);
   assign accept     = push && !full;
   assign item_valid = (count_ff != 2'd0);
   assign take_ok    = item_take && item_valid;
   assign item       = slot_ff[rd_ptr_ff];

   // Two-entry queue of classified bytes.
   always_comb begin
      wr_ptr_in = accept  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_ok ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(accept) - 2'(take_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== sv/sexpt_back.sv =====
// Back part: lexer state machine that turns classified bytes into token records.
module sexpt_back #(
   parameter int INT_WIDTH    = sexpt_pkg::INT_WIDTH_DEF,
   parameter int OFFSET_WIDTH = sexpt_pkg::OFFSET_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      positions_enabled,
   input  logic                      item_valid,
   input  sexpt_pkg::char_class_type item,
   output logic                      item_take,
   input  logic                      rec_room,
   output logic [1:0]                wr_count,
   output sexpt_pkg::token_rec_type  wr_rec0,
   output sexpt_pkg::token_rec_type  wr_rec1
);

   localparam int OW = sexpt_pkg::OUT_WIDTH;

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_INT  = 5'b00010,
      MODE_STR  = 5'b00100,
      MODE_SYM  = 5'b01000,
      MODE_SEP  = 5'b10000
   } lex_mode_type;

   lex_mode_type            mode_ff, mode_in;
   logic [INT_WIDTH-1:0]    acc_ff, acc_in;
   logic                    ov_ff, ov_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [OFFSET_WIDTH-1:0] tstart_ff, tstart_in;

   logic [INT_WIDTH+3:0]    acc_wide;
   logic [INT_WIDTH+3:0]    acc_prod;
   logic                    acc_sat;
   logic [INT_WIDTH-1:0]    acc_next;
   logic [OFFSET_WIDTH-1:0] pos;
   logic [OFFSET_WIDTH-1:0] pos_next;
   logic [OFFSET_WIDTH-1:0] tstart_next;
   logic                    close_en, start_en;
   logic                    va, vb;
   sexpt_pkg::token_rec_type rec_a, rec_b, close_rec;

   // Build a finish record; offsets read as zero when positions are off.
   function automatic sexpt_pkg::token_rec_type fin_rec(
      input sexpt_pkg::token_kind_type kind,
      input logic [OFFSET_WIDTH-1:0]   s,
      input logic [OFFSET_WIDTH-1:0]   e,
      input logic [INT_WIDTH-1:0]      val,
      input logic                      ov,
      input logic                      pe
   );
      logic [63:0] s64;
      logic [63:0] e64;
      logic [63:0] v64;
      sexpt_pkg::token_rec_type r;
      s64 = 64'(s);
      e64 = 64'(e);
      v64 = 64'(val);
      r.token_kind   = kind;
      r.record_type  = sexpt_pkg::REC_FINISH;
      r.body_char    = 8'd0;
      r.int_value    = v64[OW-1:0];
      r.int_overflow = ov;
      r.start_offset = pe ? s64[OW-1:0] : '0;
      r.end_offset   = pe ? e64[OW-1:0] : '0;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   // Build a body character record.
   function automatic sexpt_pkg::token_rec_type body_rec(
      input sexpt_pkg::token_kind_type kind,
      input logic [7:0]                ch
   );
      sexpt_pkg::token_rec_type r;
      r              = '0;
      r.token_kind   = kind;
      r.record_type  = sexpt_pkg::REC_BODY;
      r.body_char    = ch;
      return r;
   endfunction

   assign item_take   = item_valid && rec_room;
   assign pos         = offset_ff;
   assign pos_next    = offset_ff + OFFSET_WIDTH'(1);
   assign tstart_next = tstart_ff + OFFSET_WIDTH'(1);

   // Decimal accumulation: value times ten plus digit, saturating.
   always_comb begin
      acc_wide = (INT_WIDTH + 4)'(acc_ff);
      acc_prod = (acc_wide << 3) + (acc_wide << 1) +
                 (INT_WIDTH + 4)'(item.char_byte[3:0]);
      acc_sat  = (acc_prod[INT_WIDTH+3:INT_WIDTH] != 4'd0);
      acc_next = acc_sat ? {INT_WIDTH{1'b1}} : acc_prod[INT_WIDTH-1:0];
   end

   // Record that closes the open multi-byte token.
   always_comb begin
      close_rec = '0;
      case (mode_ff)
         MODE_INT: close_rec = fin_rec(sexpt_pkg::KIND_INT, tstart_ff, pos, acc_ff, ov_ff,
                                       positions_enabled);
         MODE_SYM: close_rec = fin_rec(sexpt_pkg::KIND_SYM, tstart_ff, pos, '0, 1'b0,
                                       positions_enabled);
         MODE_SEP: close_rec = fin_rec(sexpt_pkg::KIND_SEP, tstart_ff, pos, '0, 1'b0,
                                       positions_enabled);
         MODE_STR: close_rec = fin_rec(sexpt_pkg::KIND_ERR, tstart_ff, tstart_next, '0,
                                       1'b0, positions_enabled);
         default:  close_rec = '0;
      endcase
   end

   // Lexer step for one byte: at most a closing record and one more.
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      ov_in     = ov_ff;
      offset_in = offset_ff;
      tstart_in = tstart_ff;
      close_en  = 1'b0;
      start_en  = 1'b0;
      va        = 1'b0;
      vb        = 1'b0;
      rec_a     = '0;
      rec_b     = '0;

      if (item.eoi) begin
         // End of input: close any open token, then report the end.
         close_en = 1'b1;
         vb       = 1'b1;
         rec_b    = fin_rec(sexpt_pkg::KIND_END, '0, '0, '0, 1'b0, positions_enabled);
      end else begin
         offset_in = pos_next;
         case (mode_ff)
            MODE_INT: begin
               if (item.digit) begin
                  acc_in = acc_next;
                  ov_in  = ov_ff || acc_sat;
               end else begin
                  close_en = 1'b1;
                  start_en = 1'b1;
               end
            end
            MODE_SYM: begin
               if (!item.sep && !item.lpar && !item.rpar) begin
                  va    = 1'b1;
                  rec_a = body_rec(sexpt_pkg::KIND_SYM, item.upper_byte);
               end else begin
                  close_en = 1'b1;
                  start_en = 1'b1;
               end
            end
            MODE_SEP: begin
               if (!item.sep) begin
                  close_en = 1'b1;
                  start_en = 1'b1;
               end
            end
            MODE_STR: begin
               if (item.dquote) begin
                  va      = 1'b1;
                  rec_a   = fin_rec(sexpt_pkg::KIND_STR, tstart_ff, pos_next, '0, 1'b0,
                                    positions_enabled);
                  mode_in = MODE_IDLE;
               end else if (item.newline) begin
                  close_en = 1'b1;
                  start_en = 1'b1;
               end else begin
                  va    = 1'b1;
                  rec_a = body_rec(sexpt_pkg::KIND_STR, item.char_byte);
               end
            end
            default: begin
               start_en = 1'b1;
            end
         endcase
      end

      // Close the open token.
      if (close_en) begin
         va      = (mode_ff != MODE_IDLE);
         rec_a   = close_rec;
         mode_in = MODE_IDLE;
      end

      // The byte begins a new token.
      if (start_en) begin
         mode_in = MODE_IDLE;
         if (item.digit) begin
            mode_in   = MODE_INT;
            acc_in    = INT_WIDTH'(item.char_byte[3:0]);
            ov_in     = 1'b0;
            tstart_in = pos;
         end else if (item.dquote) begin
            mode_in   = MODE_STR;
            tstart_in = pos;
         end else if (item.sep) begin
            mode_in   = MODE_SEP;
            tstart_in = pos;
         end else if (item.apos) begin
            vb    = 1'b1;
            rec_b = fin_rec(sexpt_pkg::KIND_QUOTE, pos, pos_next, '0, 1'b0,
                            positions_enabled);
         end else if (item.lpar) begin
            vb    = 1'b1;
            rec_b = fin_rec(sexpt_pkg::KIND_OPEN, pos, pos_next, '0, 1'b0,
                            positions_enabled);
         end else if (item.rpar) begin
            vb    = 1'b1;
            rec_b = fin_rec(sexpt_pkg::KIND_CLOSE, pos, pos_next, '0, 1'b0,
                            positions_enabled);
         end else if (item.printable) begin
            mode_in   = MODE_SYM;
            tstart_in = pos;
            vb        = 1'b1;
            rec_b     = body_rec(sexpt_pkg::KIND_SYM, item.upper_byte);
         end else begin
            vb    = 1'b1;
            rec_b = fin_rec(sexpt_pkg::KIND_ERR, pos, pos_next, '0, 1'b0,
                            positions_enabled);
         end
      end

      // Mark the last record of this byte.
      if (vb) begin
         rec_b.last_of_run = 1'b1;
      end else begin
         rec_a.last_of_run = 1'b1;
      end
   end

   // Pack the records towards the first write port.
   assign wr_count = item_take ? (2'(va) + 2'(vb)) : 2'd0;
   assign wr_rec0  = va ? rec_a : rec_b;
   assign wr_rec1  = rec_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         acc_ff    <= '0;
         ov_ff     <= 1'b0;
         offset_ff <= '0;
         tstart_ff <= '0;
      end else if (item_take) begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         ov_ff     <= ov_in;
         offset_ff <= offset_in;
         tstart_ff <= tstart_in;
      end
   end

endmodule

// ===== sv/sexpt_rec_queue.sv =====
// Result queue: takes up to two token records a cycle and hands out one.
module sexpt_rec_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               wr_count,
   input  sexpt_pkg::token_rec_type wr_rec0,
   input  sexpt_pkg::token_rec_type wr_rec1,
   output logic                     room,
   output logic                     empty,
   input  logic                     pop,
   output sexpt_pkg::token_rec_type head
);

   localparam int PW = sexpt_pkg::REC_PTR_W;
   localparam int CW = sexpt_pkg::REC_CNT_W;

   sexpt_pkg::token_rec_type slot_ff [sexpt_pkg::REC_DEPTH];
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] wr_ptr_second;
   logic [CW-1:0] count_ff, count_in;
   logic          pop_ok;

   assign empty         = (count_ff == CW'(0));
   assign room          = (count_ff <= CW'(sexpt_pkg::REC_DEPTH - 2));
   assign pop_ok        = pop && !empty;
   assign head          = slot_ff[rd_ptr_ff];
   assign wr_ptr_second = wr_ptr_ff + PW'(1);

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(wr_count);
      rd_ptr_in = rd_ptr_ff + PW'(pop_ok);
      count_in  = count_ff + CW'(wr_count) - CW'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage needs no reset.
   always_ff @(posedge clock) begin
      if (wr_count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= wr_rec0;
      end
      if (wr_count == 2'd2) begin
         slot_ff[wr_ptr_second] <= wr_rec1;
      end
   end

endmodule

// ===== sv/s_expression_tokenizer_unit.sv =====
// S-expression tokenizer top level: byte queue, lexer, result queue and register port.
//
// Requests enter on the req_ side as one text byte or an end-of-input marker;
// a request is taken at a clock edge with req_push high and req_full low.
// Token records leave on the rsp_ side: the oldest record is on the rsp_ ports
// while rsp_empty is low and is taken at an edge with rsp_pop high.
// Each request yields zero, one or two records; the last record of a request
// carries rsp_last_of_run. Body records carry one string or symbol character,
// finish records carry the kind, integer value and byte offsets.
// A request's records reach the rsp_ ports by way of the byte queue, where the
// request is stored when it is taken, and the result queue, into which the lexer
// step writes the records when it takes the byte from the byte queue.
// Throughput: one request per cycle while each request yields at most one
// record and the receiver does not stall; the result port delivers one record
// per cycle, so a request that yields two records uses twice the result bandwidth.
// When the receiver stalls, records collect in the four-entry result queue;
// the lexer stops once fewer than two entries are free, then the two-entry
// byte queue fills and req_full rises. Nothing is lost.
// Reset empties both queues, returns the lexer to between tokens, clears the
// offset and sets positions_enabled (register 0, address 0) to one.
module s_expression_tokenizer_unit #(
   parameter int INT_WIDTH    = sexpt_pkg::INT_WIDTH_DEF,
   parameter int OFFSET_WIDTH = sexpt_pkg::OFFSET_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_next_byte,
   input  logic        req_text_end,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_token_kind,
   output logic        rsp_record_type,
   output logic [7:0]  rsp_body_char,
   output logic [31:0] rsp_int_value,
   output logic        rsp_int_overflow,
   output logic [31:0] rsp_start_offset,
   output logic [31:0] rsp_end_offset,
   output logic        rsp_last_of_run,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Register word select: bit 2 of the byte address.
   localparam int         CSR_IDX_BIT   = 2;
   localparam logic       CSR_POS_INDEX = 1'b0;

   logic                      pos_en_ff, pos_en_in;
   logic                      csr_wr;
   logic                      item_valid;
   logic                      item_take;
   sexpt_pkg::char_class_type item;
   logic                      rec_room;
   logic [1:0]                wr_count;
   sexpt_pkg::token_rec_type  wr_rec0, wr_rec1;
   sexpt_pkg::token_rec_type  head;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[CSR_IDX_BIT] == CSR_POS_INDEX);
   assign pos_en_in  = csr_wr ? csr_pwdata[0] : pos_en_ff;
   assign csr_prdata = (csr_paddr[CSR_IDX_BIT] == CSR_POS_INDEX) ?
                       {31'd0, pos_en_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_en_ff <= 1'b1;
      end else begin
         pos_en_ff <= pos_en_in;
      end
   end

   // Front: byte classification and queue.
   sexpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .next_byte  (req_next_byte),
      .text_end   (req_text_end),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // Back: lexer state machine.
   sexpt_back #(
      .INT_WIDTH    (INT_WIDTH),
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .positions_enabled (pos_en_ff),
      .item_valid        (item_valid),
      .item              (item),
      .item_take         (item_take),
      .rec_room          (rec_room),
      .wr_count          (wr_count),
      .wr_rec0           (wr_rec0),
      .wr_rec1           (wr_rec1)
   );

   // Result queue.
   sexpt_rec_queue u_rec_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_count (wr_count),
      .wr_rec0  (wr_rec0),
      .wr_rec1  (wr_rec1),
      .room     (rec_room),
      .empty    (rsp_empty),
      .pop      (rsp_pop),
      .head     (head)
   );

   assign rsp_token_kind   = head.token_kind;
   assign rsp_record_type  = head.record_type;
   assign rsp_body_char    = head.body_char;
   assign rsp_int_value    = head.int_value;
   assign rsp_int_overflow = head.int_overflow;
   assign rsp_start_offset = head.start_offset;
   assign rsp_end_offset   = head.end_offset;
   assign rsp_last_of_run  = head.last_of_run;

endmodule
